@@ rtl/grid_line_of_sight_defines.svh @@
// Assertion macros shared by the grid line-of-sight RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GRID_LINE_OF_SIGHT_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_DEFINES_SVH

// Same-cycle implication check.
`define GLOS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define GLOS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/glos_pkg.sv @@
// Shared types and constants for the grid line-of-sight block.
// No dependencies; imported by every module of the block.
package glos_pkg;

   localparam int COORD_W    = 12;
   localparam int COL_W      = 8;
   localparam int CODE_W     = 8;
   localparam int DIFF_W     = 13;
   localparam int RW         = 14;
   localparam int DIV_STEPS  = 12;
   localparam int CNT_W      = 4;
   localparam int MCOLS_W    = 7;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic REG_MAP_COLS   = 1'b0;
   localparam logic REG_FLOOR_CODE = 1'b1;

   localparam logic [MCOLS_W-1:0] MAP_COLS_RESET   = 7'd64;
   localparam logic [CODE_W-1:0]  FLOOR_CODE_RESET = 8'd46;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_A,
      ST_DIV_B,
      ST_DIFF,
      ST_SETUP,
      ST_WALK,
      ST_DRAIN,
      ST_RESP
   } glos_state_type;

   typedef struct packed {
      logic               start;
      logic [COORD_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] quot;
      logic [COL_W-1:0]   rem;
   } div_rsp_type;

endpackage

@@ rtl/glos_div.sv @@
// Restoring divider that splits a cell index into row and column, one bit a cycle.
// Depends on glos_pkg and grid_line_of_sight_defines.svh.
`include "grid_line_of_sight_defines.svh"

module glos_div #(
   parameter int MAX_COLS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  glos_pkg::div_req_type         div_req,
   input  logic [$clog2(MAX_COLS+1)-1:0] divisor,
   output glos_pkg::div_rsp_type         div_rsp
);
   import glos_pkg::*;

   localparam int CW = $clog2(MAX_COLS + 1);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [COORD_W-1:0] quot_ff, quot_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic               done_ff, done_in;
   logic [CW:0]        trial;
   logic               ge;

   always_comb begin
      trial    = {rem_ff, quot_ff[COORD_W-1]};
      ge       = trial >= {1'b0, divisor};
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         count_in = CNT_W'(DIV_STEPS);
         quot_in  = div_req.dividend;
         rem_in   = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         quot_in  = {quot_ff[COORD_W-2:0], ge};
         rem_in   = ge ? CW'(trial - {1'b0, divisor}) : CW'(trial);
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = COL_W'(rem_ff);

   `GLOS_ASSERT_IMP(a_div_start_idle, clock, reset, div_req.start, count_ff == '0, "divide started while busy")
   `GLOS_ASSERT_NXT(a_div_length, clock, reset, div_req.start, count_ff == CNT_W'(DIV_STEPS), "divide length wrong")
   `GLOS_ASSERT_IMP(a_div_rem, clock, reset, div_rsp.done, (count_ff == '0) && (rem_ff < divisor), "remainder not below divisor")

endmodule

@@ rtl/glos_map.sv @@
// Map store: one write port and one registered read port.
// Depends on glos_pkg.
module glos_map #(
   parameter int MAP_CELLS = 4096
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(MAP_CELLS)-1:0] wr_addr,
   input  logic [glos_pkg::CODE_W-1:0]  wr_data,
   input  logic [$clog2(MAP_CELLS)-1:0] rd_addr,
   output logic [glos_pkg::CODE_W-1:0]  rd_data
);
   import glos_pkg::*;

   logic [CODE_W-1:0] mem_ff [MAP_CELLS];
   logic [CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/glos_seq.sv @@
// Query sequencer: drives the shared divider, sets up the line walk and steps it
// one map read a cycle. Depends on glos_pkg and grid_line_of_sight_defines.svh.
`include "grid_line_of_sight_defines.svh"

module glos_seq #(
   parameter int MAP_CELLS = 4096,
   parameter int MAX_COLS  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          query_go,
   input  logic [glos_pkg::COORD_W-1:0]  start_pos,
   input  logic [glos_pkg::COORD_W-1:0]  end_pos,
   input  logic [$clog2(MAX_COLS+1)-1:0] cols,
   input  logic [glos_pkg::CODE_W-1:0]   floor_code,
   output glos_pkg::div_req_type         div_req,
   input  glos_pkg::div_rsp_type         div_rsp,
   output logic [$clog2(MAP_CELLS)-1:0]  rd_addr,
   input  logic [glos_pkg::CODE_W-1:0]   rd_data,
   output logic                          req_ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          rsp_visible,
   output logic [glos_pkg::COORD_W-1:0]  rsp_next_pos,
   output logic                          rsp_next_valid
);
   import glos_pkg::*;

   localparam int AW    = $clog2(MAP_CELLS);
   localparam int IDX_W = $clog2(MAP_CELLS + 4096 + MAX_COLS);

   glos_state_type state_ff, state_in;

   logic [COORD_W-1:0]       a_ff, a_in, b_ff, b_in;
   logic [COORD_W-1:0]       ar_ff, ar_in, br_ff, br_in;
   logic [COL_W-1:0]         ac_ff, ac_in, bc_ff, bc_in;
   logic signed [DIFF_W-1:0] dc_ff, dc_in, dr_ff, dr_in;
   logic [RW-1:0]            step2m_ff, step2m_in;
   logic signed [RW:0]       sub_ff, sub_in;
   logic [IDX_W-1:0]         dnc_ff, dnc_in, dcy_ff, dcy_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [RW-1:0]            r_ff, r_in;
   logic [COORD_W-1:0]       left_ff, left_in;
   logic                     first_ff, first_in;
   logic                     vis_ff, vis_in;
   logic [COORD_W-1:0]       npos_ff, npos_in;
   logic                     nvld_ff, nvld_in;
   logic                     chk_ff, chk_in;
   logic                     oor_ff, oor_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_vis_ff, rsp_vis_in;
   logic [COORD_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic                     rsp_nv_ff, rsp_nv_in;

   logic [COORD_W-1:0] adc, adr, mj, mn;
   logic               colmaj;
   logic [IDX_W-1:0]   cols_d, one_d, maj_d, min_d;
   logic [RW-1:0]      r1;
   logic signed [RW:0] r2;
   logic               carry;
   logic [IDX_W-1:0]   step_idx;
   logic               step_oor;

   assign adc    = dc_ff[DIFF_W-1] ? COORD_W'(-dc_ff) : COORD_W'(dc_ff);
   assign adr    = dr_ff[DIFF_W-1] ? COORD_W'(-dr_ff) : COORD_W'(dr_ff);
   assign colmaj = (adc >= adr) && (dc_ff != '0);
   assign mj     = colmaj ? adc : adr;
   assign mn     = colmaj ? adr : adc;
   assign cols_d = IDX_W'(cols);
   assign one_d  = IDX_W'(1);
   assign maj_d  = colmaj ? (dc_ff[DIFF_W-1] ? -one_d : one_d)
                          : (dr_ff[DIFF_W-1] ? -cols_d : cols_d);
   assign min_d  = colmaj ? (dr_ff[DIFF_W-1] ? -cols_d : cols_d)
                          : (dc_ff[DIFF_W-1] ? -one_d : one_d);

   assign r1       = r_ff + step2m_ff;
   assign r2       = $signed({1'b0, r_ff}) + sub_ff;
   assign carry    = !r2[RW];
   assign step_idx = idx_ff + (carry ? dcy_ff : dnc_ff);
   assign step_oor = step_idx >= IDX_W'(MAP_CELLS);
   assign rd_addr  = AW'(step_idx);

   assign div_req.start    = ((state_ff == ST_IDLE) && query_go)
                           || ((state_ff == ST_DIV_A) && div_rsp.done);
   assign div_req.dividend = (state_ff == ST_IDLE) ? start_pos : b_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      ar_in        = ar_ff;
      br_in        = br_ff;
      ac_in        = ac_ff;
      bc_in        = bc_ff;
      dc_in        = dc_ff;
      dr_in        = dr_ff;
      step2m_in    = step2m_ff;
      sub_in       = sub_ff;
      dnc_in       = dnc_ff;
      dcy_in       = dcy_ff;
      idx_in       = idx_ff;
      r_in         = r_ff;
      left_in      = left_ff;
      first_in     = first_ff;
      vis_in       = vis_ff;
      npos_in      = npos_ff;
      nvld_in      = nvld_ff;
      chk_in       = 1'b0;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_vis_in   = rsp_vis_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_nv_in    = rsp_nv_ff;

      if (chk_ff && (oor_ff || (rd_data != floor_code))) begin
         vis_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               a_in     = start_pos;
               b_in     = end_pos;
               state_in = ST_DIV_A;
            end
         end
         ST_DIV_A: begin
            if (div_rsp.done) begin
               ar_in    = div_rsp.quot;
               ac_in    = div_rsp.rem;
               state_in = ST_DIV_B;
            end
         end
         ST_DIV_B: begin
            if (div_rsp.done) begin
               br_in    = div_rsp.quot;
               bc_in    = div_rsp.rem;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            dr_in    = $signed({1'b0, br_ff}) - $signed({1'b0, ar_ff});
            dc_in    = $signed({{(DIFF_W-COL_W){1'b0}}, bc_ff})
                     - $signed({{(DIFF_W-COL_W){1'b0}}, ac_ff});
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            step2m_in = {1'b0, mn, 1'b0};
            sub_in    = $signed({2'b00, mn, 1'b0}) - $signed({2'b00, mj, 1'b0});
            dnc_in    = maj_d;
            dcy_in    = maj_d + min_d;
            idx_in    = IDX_W'(a_ff);
            r_in      = RW'(mj);
            left_in   = mj - 1'b1;
            first_in  = 1'b1;
            vis_in    = 1'b1;
            priority if (mj == '0) begin
               npos_in  = '0;
               nvld_in  = 1'b0;
               state_in = ST_RESP;
            end else if (mj == COORD_W'(1)) begin
               npos_in  = b_ff;
               nvld_in  = 1'b1;
               state_in = ST_RESP;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            idx_in   = step_idx;
            r_in     = carry ? RW'(r2) : r1;
            left_in  = left_ff - 1'b1;
            first_in = 1'b0;
            chk_in   = 1'b1;
            oor_in   = step_oor;
            if (first_ff) begin
               nvld_in = !step_oor && (step_idx[IDX_W-1:COORD_W] == '0);
               npos_in = (!step_oor && (step_idx[IDX_W-1:COORD_W] == '0))
                       ? step_idx[COORD_W-1:0] : '0;
            end
            if (left_ff == COORD_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_vis_in   = vis_in;
               rsp_pos_in   = npos_ff;
               rsp_nv_in    = nvld_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      ar_ff     <= ar_in;
      br_ff     <= br_in;
      ac_ff     <= ac_in;
      bc_ff     <= bc_in;
      dc_ff     <= dc_in;
      dr_ff     <= dr_in;
      step2m_ff <= step2m_in;
      sub_ff    <= sub_in;
      dnc_ff    <= dnc_in;
      dcy_ff    <= dcy_in;
      idx_ff    <= idx_in;
      r_ff      <= r_in;
      left_ff   <= left_in;
      first_ff  <= first_in;
      vis_ff    <= vis_in;
      npos_ff   <= npos_in;
      nvld_ff   <= nvld_in;
      oor_ff    <= oor_in;
      rsp_vis_ff <= rsp_vis_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_nv_ff  <= rsp_nv_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_visible    = rsp_vis_ff;
   assign rsp_next_pos   = rsp_pos_ff;
   assign rsp_next_valid = rsp_nv_ff;

   `GLOS_ASSERT_IMP(a_walk_left, clock, reset, state_ff == ST_WALK, left_ff != '0, "walk with no cells left")
   `GLOS_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_RESP), "response loaded outside RESP")
   `GLOS_ASSERT_IMP(a_chk_source, clock, reset, chk_ff, (state_ff == ST_WALK) || (state_ff == ST_DRAIN), "cell check outside walk")

endmodule

@@ rtl/grid_line_of_sight.sv @@
// Grid line-of-sight: a write request (tuser 0) stores one map cell code.
// A query request (tuser 1) splits start and end into row and column on a shared
// restoring divider (12 quotient bits per split), passes the DIFF and SETUP states, then
// walks the D - 1 cells strictly between the points along the major axis, one map read
// per cycle; the DRAIN state checks the last read and the RESP state loads the result.
// D is the larger of the column and row distance; when D is 0 or 1 the walk and DRAIN
// are skipped. The input is ready again in the same cycle the result becomes valid, and
// a new query is taken only once the last one is through; a result still waiting in the
// output register holds the query in its RESP state and so delays the next. The map is
// not cleared at reset: every cell must be written before a query reaches it. One result
// leaves per query, none per write.
module grid_line_of_sight #(
   parameter int MAP_CELLS = 4096,
   parameter int MAX_COLS  = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [11:0] cell_index, [19:12] cell_code, [31:20] start_pos, [43:32] end_pos
   input  logic [glos_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] cmd
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] visible, [12:1] next_pos, [13] next_valid
   output logic [glos_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [glos_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [glos_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [glos_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import glos_pkg::*;

   localparam int AW = $clog2(MAP_CELLS);
   localparam int CW = $clog2(MAX_COLS + 1);

   logic [MCOLS_W-1:0] map_cols_ff;
   logic [CODE_W-1:0]  floor_code_ff;
   logic [CW-1:0]      cols;
   logic               csr_wr;
   logic               req_acc;
   logic               wr_en;
   logic               query_go;
   logic [COORD_W-1:0] cell_index, start_pos, end_pos;
   logic [CODE_W-1:0]  cell_code;
   logic [CODE_W-1:0]  rd_data;
   logic [AW-1:0]      rd_addr;
   logic               rsp_visible, rsp_next_valid;
   logic [COORD_W-1:0] rsp_next_pos;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_cols_ff   <= MAP_COLS_RESET;
         floor_code_ff <= FLOOR_CODE_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_MAP_COLS:   map_cols_ff   <= csr_pwdata[MCOLS_W-1:0];
            REG_FLOOR_CODE: floor_code_ff <= csr_pwdata[CODE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MAP_COLS:   csr_prdata = CSR_DATA_W'(map_cols_ff);
         REG_FLOOR_CODE: csr_prdata = CSR_DATA_W'(floor_code_ff);
      endcase
   end

   always_comb begin
      priority if (map_cols_ff == '0) begin
         cols = CW'(1);
      end else if (int'(map_cols_ff) > MAX_COLS) begin
         cols = CW'(MAX_COLS);
      end else begin
         cols = CW'(map_cols_ff);
      end
   end

   assign cell_index = req_tdata[11:0];
   assign cell_code  = req_tdata[19:12];
   assign start_pos  = req_tdata[31:20];
   assign end_pos    = req_tdata[43:32];

   assign req_acc  = req_tvalid && req_tready;
   assign wr_en    = req_acc && (req_tuser == CMD_WRITE) && (int'(cell_index) < MAP_CELLS);
   assign query_go = req_acc && (req_tuser == CMD_QUERY);

   glos_div #(
      .MAX_COLS (MAX_COLS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .divisor (cols),
      .div_rsp (div_rsp)
   );

   glos_map #(
      .MAP_CELLS (MAP_CELLS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(cell_index)),
      .wr_data (cell_code),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   glos_seq #(
      .MAP_CELLS (MAP_CELLS),
      .MAX_COLS  (MAX_COLS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .query_go       (query_go),
      .start_pos      (start_pos),
      .end_pos        (end_pos),
      .cols           (cols),
      .floor_code     (floor_code_ff),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .req_ready      (req_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_visible    (rsp_visible),
      .rsp_next_pos   (rsp_next_pos),
      .rsp_next_valid (rsp_next_valid)
   );

   assign rsp_tdata = {2'b00, rsp_next_valid, rsp_next_pos, rsp_visible};

endmodule
